// File: rtl/topological_sort_kahn_unit_assert.svh
// Assertion macros used by the topological sort controller.
`ifndef TOPOLOGICAL_SORT_KAHN_UNIT_ASSERT_SVH
`define TOPOLOGICAL_SORT_KAHN_UNIT_ASSERT_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define TSK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition always holds.
`define TSK_ASSERT_ALW(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("assertion failed");

`endif

// File: rtl/tsk_pkg.sv
`timescale 1ns / 1ps
package tsk_pkg;
  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned MaxEdgesDef = 256;
  localparam int unsigned CfgWidth = 7;
  localparam logic [CfgWidth-1:0] VertexCountReset = 7'd64;
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_RUN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_DEG,
    ST_CNT,
    ST_SEED_RD,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_EDGE_RD,
    ST_EDGE_DEG,
    ST_EDGE,
    ST_EMIT,
    ST_EMIT_WAIT,
    ST_CYCLE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add_edge;
    logic vtx_start;
    logic vtx_step;
    logic clr_deg;
    logic deg_vtx;
    logic edge_start_fwd;
    logic edge_start_back;
    logic edge_inc;
    logic edge_dec;
    logic cnt_apply;
    logic seed_apply;
    logic dec_apply;
    logic pop;
    logic out_load;
    logic out_cycle;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic vtx_done;
    logic edge_fwd_last;
    logic edge_back_last;
    logic fifo_empty;
    logic all_visited;
    logic has_edges;
  } status_t;
endpackage

// File: rtl/tsk_ram.sv
`timescale 1ns / 1ps
module tsk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/tsk_datapath.sv
`timescale 1ns / 1ps
module tsk_datapath import tsk_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  parameter int unsigned MaxEdges = MaxEdgesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [CfgWidth-1:0] vertex_count_i,
  input  logic [5:0]          src_i,
  input  logic [5:0]          dst_i,
  output logic [5:0]          order_vertex_o,
  output logic                cycle_found_o,
  output logic                is_last_o
);
  localparam int unsigned VW = $clog2(MaxVertices);
  localparam int unsigned VCW = $clog2(MaxVertices + 1);
  localparam int unsigned EW = $clog2(MaxEdges);
  localparam int unsigned ECW = $clog2(MaxEdges + 1);
  localparam int unsigned DW = ECW;

  logic [VCW-1:0] n_eff;
  logic [ECW-1:0] edge_total_q, edge_total_d;
  logic [ECW-1:0] eidx_q, eidx_d;
  logic [VCW-1:0] vidx_q, vidx_d;
  logic [VCW-1:0] head_q, head_d, tail_q, tail_d;
  logic [VW-1:0]  cur_q, cur_d;
  logic [5:0] e_src, e_dst, f_rd, o_rd;
  logic       add_ok, e_valid, dec_hit;
  logic [EW-1:0] e_raddr;
  logic fifo_we, ord_we;
  logic [VW-1:0] fifo_wa, fifo_ra, ord_ra, fifo_wd;
  logic          deg_we;
  logic [VW-1:0] deg_wa, deg_ra;
  logic [DW-1:0] deg_wd, deg_rd;
  logic [5:0] out_v_q;
  logic out_c_q, out_l_q;

  // Effective vertex count, clamped to the legal range.
  always_comb begin
    if (vertex_count_i == '0) begin
      n_eff = VCW'(1);
    end else if (32'(vertex_count_i) > MaxVertices) begin
      n_eff = VCW'(MaxVertices);
    end else begin
      n_eff = VCW'(vertex_count_i);
    end
  end

  assign add_ok = (32'(edge_total_q) < MaxEdges) && (7'(src_i) < 7'(n_eff)) &&
                  (7'(dst_i) < 7'(n_eff));
  assign e_raddr = eidx_q[EW-1:0];
  assign e_valid = (7'(e_src) < 7'(n_eff)) && (7'(e_dst) < 7'(n_eff));

  tsk_ram #(.Width(6), .Depth(MaxEdges)) u_src_ram (
    .clk_i, .we_i(cmd_i.add_edge && add_ok), .waddr_i(edge_total_q[EW-1:0]),
    .wdata_i(src_i), .raddr_i(e_raddr), .rdata_o(e_src));
  tsk_ram #(.Width(6), .Depth(MaxEdges)) u_dst_ram (
    .clk_i, .we_i(cmd_i.add_edge && add_ok), .waddr_i(edge_total_q[EW-1:0]),
    .wdata_i(dst_i), .raddr_i(e_raddr), .rdata_o(e_dst));

  // In-degree table: read at the vertex index while seeding, else at the
  // destination of the edge being read.
  assign deg_ra = cmd_i.deg_vtx ? vidx_q[VW-1:0] : e_dst[VW-1:0];
  tsk_ram #(.Width(DW), .Depth(MaxVertices)) u_deg_ram (
    .clk_i, .we_i(deg_we), .waddr_i(deg_wa), .wdata_i(deg_wd),
    .raddr_i(deg_ra), .rdata_o(deg_rd));

  // An edge of the popped vertex whose destination still has in-degree.
  assign dec_hit = cmd_i.dec_apply && e_valid && (e_src[VW-1:0] == cur_q) &&
                   (deg_rd != '0);

  // In-degree writes: clear, count up or count down, one per cycle.
  always_comb begin
    deg_we = 1'b0;
    deg_wa = e_dst[VW-1:0];
    deg_wd = '0;
    if (cmd_i.clr_deg) begin
      deg_we = 1'b1;
      deg_wa = vidx_q[VW-1:0];
    end else if (cmd_i.cnt_apply && e_valid) begin
      deg_we = 1'b1;
      deg_wd = deg_rd + DW'(1);
    end else if (dec_hit) begin
      deg_we = 1'b1;
      deg_wd = deg_rd - DW'(1);
    end
  end

  // Order RAM copies each FIFO write; pops never overwrite entries.
  assign fifo_ra = head_q[VW-1:0];
  assign ord_ra = vidx_q[VW-1:0];
  tsk_ram #(.Width(6), .Depth(MaxVertices)) u_fifo_ram (
    .clk_i, .we_i(fifo_we), .waddr_i(fifo_wa), .wdata_i(6'(fifo_wd)),
    .raddr_i(fifo_ra), .rdata_o(f_rd));
  tsk_ram #(.Width(6), .Depth(MaxVertices)) u_ord_ram (
    .clk_i, .we_i(ord_we), .waddr_i(fifo_wa), .wdata_i(6'(fifo_wd)),
    .raddr_i(ord_ra), .rdata_o(o_rd));

  // Index counters, FIFO pointers and FIFO writes.
  always_comb begin
    edge_total_d = edge_total_q;
    eidx_d = eidx_q;
    vidx_d = vidx_q;
    head_d = head_q;
    tail_d = tail_q;
    cur_d = cur_q;
    fifo_we = 1'b0;
    fifo_wa = tail_q[VW-1:0];
    fifo_wd = vidx_q[VW-1:0];
    if (cmd_i.add_edge && add_ok) edge_total_d = edge_total_q + ECW'(1);
    if (cmd_i.vtx_start) vidx_d = '0;
    else if (cmd_i.vtx_step) vidx_d = vidx_q + VCW'(1);
    if (cmd_i.edge_start_fwd) begin
      eidx_d = '0;
      head_d = '0;
      tail_d = '0;
    end else if (cmd_i.edge_start_back) begin
      eidx_d = edge_total_q - ECW'(1);
    end else if (cmd_i.edge_inc) begin
      eidx_d = eidx_q + ECW'(1);
    end else if (cmd_i.edge_dec) begin
      eidx_d = eidx_q - ECW'(1);
    end
    if (cmd_i.seed_apply && deg_rd == '0) begin
      fifo_we = 1'b1;
      tail_d = tail_q + VCW'(1);
    end
    if (dec_hit && deg_rd == DW'(1)) begin
      fifo_we = 1'b1;
      fifo_wd = e_dst[VW-1:0];
      tail_d = tail_q + VCW'(1);
    end
    if (cmd_i.pop) begin
      cur_d = f_rd[VW-1:0];
      head_d = head_q + VCW'(1);
    end
  end
  assign ord_we = fifo_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      eidx_q <= '0;
      vidx_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      cur_q <= '0;
    end else begin
      edge_total_q <= edge_total_d;
      eidx_q <= eidx_d;
      vidx_q <= vidx_d;
      head_q <= head_d;
      tail_q <= tail_d;
      cur_q <= cur_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_v_q <= cmd_i.out_cycle ? 6'd0 : o_rd;
      out_c_q <= cmd_i.out_cycle;
      out_l_q <= cmd_i.out_cycle || (vidx_q == n_eff - VCW'(1));
    end
  end
  assign order_vertex_o = out_v_q;
  assign cycle_found_o = out_c_q;
  assign is_last_o = out_l_q;

  assign status_o.vtx_done = (vidx_q == n_eff - VCW'(1));
  assign status_o.edge_fwd_last = (eidx_q == edge_total_q - ECW'(1));
  assign status_o.edge_back_last = (eidx_q == '0);
  assign status_o.fifo_empty = (head_q == tail_q);
  assign status_o.all_visited = (tail_q == n_eff);
  assign status_o.has_edges = (edge_total_q != '0);
endmodule

// File: rtl/tsk_ctrl.sv
`timescale 1ns / 1ps
`include "topological_sort_kahn_unit_assert.svh"
module tsk_ctrl import tsk_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    req_type_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);
  state_e state_q, state_d;
  logic ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    ov_d = ov_q && !out_ready_i;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !ov_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          if (req_type_i == REQ_ADD) begin
            cmd_o.add_edge = 1'b1;
          end else begin
            cmd_o.vtx_start = 1'b1;
            state_d = ST_CLR;
          end
        end
      end
      ST_CLR: begin
        cmd_o.clr_deg = 1'b1;
        if (status_i.vtx_done) begin
          cmd_o.vtx_start = 1'b1;
          cmd_o.edge_start_fwd = 1'b1;
          state_d = status_i.has_edges ? ST_CNT_RD : ST_SEED_RD;
        end else begin
          cmd_o.vtx_step = 1'b1;
        end
      end
      ST_CNT_RD: state_d = ST_CNT_DEG;
      ST_CNT_DEG: state_d = ST_CNT;
      ST_CNT: begin
        cmd_o.cnt_apply = 1'b1;
        cmd_o.edge_inc = 1'b1;
        state_d = status_i.edge_fwd_last ? ST_SEED_RD : ST_CNT_RD;
      end
      ST_SEED_RD: begin
        cmd_o.deg_vtx = 1'b1;
        state_d = ST_SEED;
      end
      ST_SEED: begin
        cmd_o.seed_apply = 1'b1;
        cmd_o.vtx_step = 1'b1;
        state_d = status_i.vtx_done ? ST_POP_WAIT : ST_SEED_RD;
      end
      ST_POP_WAIT: begin
        if (status_i.fifo_empty) begin
          state_d = status_i.all_visited ? ST_EMIT_WAIT : ST_CYCLE;
          cmd_o.vtx_start = 1'b1;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
        if (status_i.has_edges) begin
          cmd_o.edge_start_back = 1'b1;
          state_d = ST_EDGE_RD;
        end else begin
          state_d = ST_POP_WAIT;
        end
      end
      ST_EDGE_RD: state_d = ST_EDGE_DEG;
      ST_EDGE_DEG: state_d = ST_EDGE;
      ST_EDGE: begin
        cmd_o.dec_apply = 1'b1;
        cmd_o.edge_dec = 1'b1;
        state_d = status_i.edge_back_last ? ST_POP_WAIT : ST_EDGE_RD;
      end
      ST_CYCLE: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_cycle = 1'b1;
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_WAIT: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.vtx_step = 1'b1;
          ov_d = 1'b1;
          state_d = status_i.vtx_done ? ST_IDLE : ST_EMIT_WAIT;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
  assign out_valid_o = ov_q;

  // Input is only taken between runs.
  `TSK_ASSERT_IMP(a_ready_only_idle, clk_i, rst_ni, in_ready_o, state_q == ST_IDLE)
  // The output register is never overwritten while a beat waits.
  `TSK_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, cmd_o.out_load, !ov_q || out_ready_i)
  // A waiting beat stays valid until it is taken.
  `TSK_ASSERT_IMP(a_valid_held, clk_i, rst_ni, ov_q && !out_ready_i, ov_d)
  // Counting and decrementing never overlap.
  `TSK_ASSERT_ALW(a_one_deg_op, clk_i, rst_ni, !(cmd_o.cnt_apply && cmd_o.dec_apply))
endmodule

// File: rtl/topological_sort_kahn_unit.sv
`timescale 1ns / 1ps
// Kahn topological sort unit.
// Input stream (s_axis): one beat per request. tuser is req_type (0 adds an
// edge, 1 runs the sort); tdata carries src_vertex and dst_vertex. An add
// beat is taken every cycle while idle with no output beat waiting, and
// produces no output; it is dropped if the edge store is full or a vertex
// is at or beyond the clamped vertex_count. A run beat clears the in-degree
// table, counts in-degrees over the E stored edges, seeds the ready FIFO,
// then for each visited vertex walks the whole edge store newest first.
// Each edge step passes through a read, an in-degree read and an update
// state, as the edge and in-degree memories have single registered read
// ports. No input is taken during a run.
// Output stream (m_axis): n beats of order_vertex with tlast on the final
// one, or one beat with tuser (cycle_found) set when a cycle exists. Each
// order beat passes through a wait state and an emit state. A stalled
// receiver holds the output register and the sort waits; while the final
// beat waits, input is held off too. No beat is lost.
// The APB port holds vertex_count at address 0 (reset 64).
// Reset clears the edge count, so the edge store is empty after reset.
module topological_sort_kahn_unit import tsk_pkg::*; #(
  parameter int unsigned MaxVertices = MaxVerticesDef,
  parameter int unsigned MaxEdges = MaxEdgesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [5:0] src_vertex, [11:6] dst_vertex
  input  logic        s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [5:0] order_vertex
  output logic        m_axis_tuser,  // [0] cycle_found
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [CfgWidth-1:0] vc_q;
  cmd_t cmd;
  status_t status;
  logic [5:0] ov;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VertexCountReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      vc_q <= pwdata[CfgWidth-1:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {25'd0, vc_q} : 32'd0;

  tsk_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .req_type_i(s_axis_tuser),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_i(status), .cmd_o(cmd));

  tsk_datapath #(.MaxVertices(MaxVertices), .MaxEdges(MaxEdges)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .vertex_count_i(vc_q),
    .src_i(s_axis_tdata[5:0]), .dst_i(s_axis_tdata[11:6]),
    .order_vertex_o(ov), .cycle_found_o(m_axis_tuser), .is_last_o(m_axis_tlast));
  assign m_axis_tdata = {2'b00, ov};
endmodule
